// ----- hw/rtl/dotq_pkg.sv -----
// package for the deadline ordered timer queue
// types, codes and sizes shared by the store and top level
package dotq_pkg;

	localparam int DOTQ_TIMERS = 16;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_POLL  = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		EV_FIRED  = 2'd0,
		EV_REPORT = 2'd1,
		EV_DONE   = 2'd2,
		EV_REJECT = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_REM,
		S_CHK,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] now;
		logic [7:0]  timer_tag;
		logic [31:0] start_delay;
		logic [31:0] period;
		logic        repeat_req;
	} in_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [7:0]  fired_tag;
		logic [31:0] remaining;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [31:0] dl;
		logic [31:0] per;
		logic [7:0]  tag;
		logic        rep;
		logic        fired;
	} entry_t;

endpackage

// ----- hw/rtl/dotq_alu.sv -----
// shared compare and subtract unit of the timer queue
// depends on nothing; gives a < b and b - a
module dotq_alu (
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        lt,
	output logic [31:0] diff
);
	assign lt   = a < b;
	assign diff = b - a;
endmodule

// ----- hw/rtl/dotq_store.sv -----
// timer slot store: one read and one write address per cycle
// depends on dotq_pkg for the entry type
module dotq_store #(
	parameter int TIMERS = dotq_pkg::DOTQ_TIMERS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [$clog2(TIMERS)-1:0] rd_idx,
	output dotq_pkg::entry_t          rd_data,
	input  logic                      we,
	input  logic [$clog2(TIMERS)-1:0] wr_idx,
	input  dotq_pkg::entry_t          wr_data,
	input  logic                      clr_fired
);
	import dotq_pkg::*;

	logic [31:0] dl_q  [TIMERS];
	logic [31:0] per_q [TIMERS];
	logic [7:0]  tag_q [TIMERS];
	logic        rep_q [TIMERS];
	logic [TIMERS-1:0] fired_q;

	always_ff @(posedge clk) begin
		if (we) begin
			dl_q[wr_idx]  <= wr_data.dl;
			per_q[wr_idx] <= wr_data.per;
			tag_q[wr_idx] <= wr_data.tag;
			rep_q[wr_idx] <= wr_data.rep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fired_q <= '0;
		end else if (clr_fired) begin
			fired_q <= '0;
		end else if (we) begin
			fired_q[wr_idx] <= wr_data.fired;
		end
	end

	assign rd_data = '{dl: dl_q[rd_idx], per: per_q[rd_idx], tag: tag_q[rd_idx],
		rep: rep_q[rd_idx], fired: fired_q[rd_idx]};
endmodule

// ----- hw/rtl/deadline_ordered_timer_queue_core.sv -----
// top level of the deadline ordered timer queue: sequencer and output register
// depends on dotq_pkg, dotq_store and dotq_alu
//
// Keeps up to TIMERS timers sorted by deadline in a slot store walked one entry a
// cycle through a single compare/subtract unit. One item is handled at a time and
// in_stall stays high until its last result transfer. A start walks the entries
// that must move to open its slot, and a start on a full queue is rejected; clear
// resets the count. A poll, per fired timer, checks the head, removes it and, for a
// repeating timer, re-inserts it, gives one result, and ends with a report; a
// result is held while out_stall is high. No clearing pass is needed after reset.
module deadline_ordered_timer_queue_core #(
	parameter int TIMERS = dotq_pkg::DOTQ_TIMERS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  dotq_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output dotq_pkg::out_t out_data
);
	import dotq_pkg::*;

	localparam int IW = $clog2(TIMERS);
	localparam int CW = $clog2(TIMERS + 1);

	state_t state_q, state_d, ret_q;
	logic [CW-1:0] count_q, n_q;
	logic [IW-1:0] pos_q, rd_idx, wr_idx;
	logic [31:0]   now_q, ins_dl_q, ins_per_q;
	logic [7:0]    ins_tag_q;
	logic          ins_rep_q, ins_fired_q, is_poll_q;
	out_t          out_q;
	logic          out_valid_q;
	entry_t        rd_data, wr_data, ins_entry;
	logic          we, clr_fired;
	logic [31:0]   alu_a, alu_diff;
	logic          alu_lt, fire_ok, ins_done, rem_more;
	logic [CW-1:0] pos_up;

	dotq_store #(.TIMERS(TIMERS)) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (rd_idx),
		.rd_data  (rd_data),
		.we       (we),
		.wr_idx   (wr_idx),
		.wr_data  (wr_data),
		.clr_fired(clr_fired)
	);

	assign alu_a = (state_q == S_INS) ? ins_dl_q : now_q;

	dotq_alu u_alu (
		.a   (alu_a),
		.b   (rd_data.dl),
		.lt  (alu_lt),
		.diff(alu_diff)
	);

	assign ins_entry = '{dl: ins_dl_q, per: ins_per_q, tag: ins_tag_q, rep: ins_rep_q,
		fired: ins_fired_q};
	assign pos_up    = CW'(pos_q) + CW'(1);
	assign ins_done  = (pos_q == '0) || !alu_lt;
	assign rem_more  = pos_up < count_q;
	// head already fired this poll stops the sweep
	assign fire_ok   = (count_q != '0) && !rd_data.fired && !alu_lt && (n_q < CW'(TIMERS));
	assign wr_idx    = pos_q;

	always_comb begin
		state_d   = state_q;
		rd_idx    = '0;
		we        = 1'b0;
		wr_data   = rd_data;
		clr_fired = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (in_data.kind)
						KIND_START: state_d = (count_q == CW'(TIMERS)) ? S_OUT : S_INS;
						KIND_CLEAR: state_d = S_OUT;
						KIND_POLL: begin
							clr_fired = 1'b1;
							state_d   = S_CHK;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_INS: begin
				rd_idx = pos_q - IW'(1);
				we     = 1'b1;
				if (ins_done) begin
					wr_data = ins_entry;
					state_d = S_OUT;
				end
			end
			S_REM: begin
				rd_idx = pos_up[IW-1:0];
				if (rem_more) begin
					we = 1'b1;
				end else begin
					state_d = ins_rep_q ? S_INS : S_OUT;
				end
			end
			S_CHK: state_d = fire_ok ? S_REM : S_OUT;
			S_OUT: begin
				if (!out_stall) begin
					state_d = ret_q;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			count_q     <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
			is_poll_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= (state_d == S_OUT);
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (in_data.kind)
							KIND_START: begin
								is_poll_q <= 1'b0;
								ret_q     <= S_IDLE;
								if (count_q == CW'(TIMERS)) begin
									out_q <= '{event_res: EV_REJECT, fired_tag: '0,
										remaining: '0, last: 1'b1};
								end
							end
							KIND_CLEAR: begin
								count_q <= '0;
								ret_q   <= S_IDLE;
								out_q   <= '{event_res: EV_DONE, fired_tag: '0,
									remaining: '0, last: 1'b1};
							end
							KIND_POLL: begin
								is_poll_q <= 1'b1;
								n_q       <= '0;
							end
							default: ;
						endcase
					end
				end
				S_INS: begin
					if (ins_done) begin
						count_q <= count_q + CW'(1);
						if (is_poll_q) begin
							n_q   <= n_q + CW'(1);
							ret_q <= S_CHK;
							out_q <= '{event_res: EV_FIRED, fired_tag: ins_tag_q,
								remaining: '0, last: 1'b0};
						end else begin
							ret_q <= S_IDLE;
							out_q <= '{event_res: EV_DONE, fired_tag: '0,
								remaining: '0, last: 1'b1};
						end
					end
				end
				S_REM: begin
					if (!rem_more) begin
						count_q <= count_q - CW'(1);
						if (!ins_rep_q) begin
							n_q   <= n_q + CW'(1);
							ret_q <= S_CHK;
							out_q <= '{event_res: EV_FIRED, fired_tag: ins_tag_q,
								remaining: '0, last: 1'b0};
						end
					end
				end
				S_CHK: begin
					if (!fire_ok) begin
						ret_q <= S_IDLE;
						out_q <= '{event_res: EV_REPORT, fired_tag: '0,
							remaining: ((count_q != '0) && alu_lt) ? alu_diff : 32'd0,
							last: 1'b1};
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					now_q       <= in_data.now;
					ins_dl_q    <= in_data.period + in_data.start_delay + in_data.now;
					ins_per_q   <= in_data.period;
					ins_tag_q   <= in_data.timer_tag;
					ins_rep_q   <= in_data.repeat_req;
					ins_fired_q <= 1'b0;
					pos_q       <= count_q[IW-1:0];
				end
			end
			S_INS: begin
				if (!ins_done) begin
					pos_q <= pos_q - IW'(1);
				end
			end
			S_REM: begin
				if (rem_more) begin
					pos_q <= pos_up[IW-1:0];
				end else begin
					pos_q <= IW'(count_q - CW'(1));
				end
			end
			S_CHK: begin
				if (fire_ok) begin
					ins_dl_q    <= now_q + rd_data.per;
					ins_per_q   <= rd_data.per;
					ins_tag_q   <= rd_data.tag;
					ins_rep_q   <= rd_data.rep;
					ins_fired_q <= 1'b1;
					pos_q       <= '0;
				end
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TIMERS)) else $error("queue count beyond capacity");
	a_idle_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !out_valid_q) else $error("result pending while idle");
	a_fire_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CW'(TIMERS)) else $error("too many timers fired in one poll");
endmodule

// ----- tb/deadline_ordered_timer_queue_core_tb.sv -----
// testbench for deadline_ordered_timer_queue_core: random and directed start/poll/clear traffic
// depends on dotq_pkg and the core; predicts results with its own sorted timer list
`timescale 1ns / 1ps

module deadline_ordered_timer_queue_core_tb;
	import dotq_pkg::*;

	localparam int NT = DOTQ_TIMERS;
	localparam int IDLE_LIMIT = 20000;

	class timer_list_sb;
		entry_t slots[$];
		out_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function void put_sorted(entry_t e);
			int pos;
			pos = 0;
			while (pos < slots.size() && !(e.dl < slots[pos].dl))
				pos++;
			slots.insert(pos, e);
		endfunction

		function void add_result(event_t ev, logic [7:0] tg, logic [31:0] rem, logic fin);
			out_t r;
			r.event_res = ev;
			r.fired_tag = tg;
			r.remaining = rem;
			r.last = fin;
			pending.push_back(r);
		endfunction

		// works out the results of one accepted transfer and updates the list
		function void note_input(in_t it);
			entry_t e, h;
			int n;
			logic [31:0] rem;
			case (it.kind)
				KIND_START: begin
					if (slots.size() >= NT) begin
						add_result(EV_REJECT, 8'd0, 32'd0, 1'b1);
					end else begin
						e.dl = it.period + it.start_delay + it.now;
						e.per = it.period;
						e.tag = it.timer_tag;
						e.rep = it.repeat_req;
						e.fired = 1'b0;
						put_sorted(e);
						add_result(EV_DONE, 8'd0, 32'd0, 1'b1);
					end
				end
				KIND_CLEAR: begin
					slots.delete();
					add_result(EV_DONE, 8'd0, 32'd0, 1'b1);
				end
				KIND_POLL: begin
					n = 0;
					rem = 0;
					foreach (slots[i])
						slots[i].fired = 1'b0;
					while (slots.size() > 0 && !slots[0].fired && !(it.now < slots[0].dl)
							&& n < NT) begin
						h = slots.pop_front();
						if (h.rep) begin
							h.dl = it.now + h.per;
							h.fired = 1'b1;
							put_sorted(h);
						end
						add_result(EV_FIRED, h.tag, 32'd0, 1'b0);
						n++;
					end
					if (slots.size() > 0 && it.now < slots[0].dl)
						rem = slots[0].dl - it.now;
					add_result(EV_REPORT, 8'd0, rem, 1'b1);
				end
				default: ;
			endcase
		endfunction

		function void check_result(out_t got);
			out_t exp_r;
			if (pending.size() == 0) begin
				$error("unexpected result %p", got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.event_res !== exp_r.event_res) begin
				$error("event_res exp %0d got %0d", exp_r.event_res, got.event_res);
				errors++;
			end
			if (got.fired_tag !== exp_r.fired_tag) begin
				$error("fired_tag exp %0d got %0d", exp_r.fired_tag, got.fired_tag);
				errors++;
			end
			if (got.remaining !== exp_r.remaining) begin
				$error("remaining exp %0d got %0d", exp_r.remaining, got.remaining);
				errors++;
			end
			if (got.last !== exp_r.last) begin
				$error("last exp %0d got %0d", exp_r.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_t in_data;
	logic out_valid;
	logic out_stall;
	out_t out_data;

	timer_list_sb sb;
	int idle_cycles;
	bit gaps_on;
	logic [31:0] t_now;

	deadline_ordered_timer_queue_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// check transfers and run the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(out_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// receiver stalls drawn per result, with stretches of none
	initial begin
		int w;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			w = gaps_on ? $urandom_range(0, 11) : 0;
			if (w > 0) begin
				out_stall <= 1'b1;
				repeat (w) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!(out_valid && !out_stall))
				@(posedge clk);
		end
	end

	// valid stays up after a transfer until the next item or gap replaces it
	task automatic send(in_t it);
		int w;
		w = gaps_on ? $urandom_range(0, 11) : 0;
		if (w > 0) begin
			in_valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(it);
	endtask

	task automatic send_item(kind_t k, logic [31:0] nw, logic [7:0] tg, logic [31:0] dly,
			logic [31:0] per, logic rep);
		in_t it;
		it.kind = k;
		it.now = nw;
		it.timer_tag = tg;
		it.start_delay = dly;
		it.period = per;
		it.repeat_req = rep;
		send(it);
	endtask

	// random traffic: time advances, small delays so polls fire timers, plus noise items
	task automatic random_item();
		int r;
		in_t it;
		r = $urandom_range(0, 99);
		t_now = t_now + $urandom_range(0, 40);
		it.now = t_now;
		it.timer_tag = 8'($urandom);
		it.start_delay = $urandom_range(0, 30);
		it.period = $urandom_range(0, 30);
		it.repeat_req = 1'($urandom);
		if (r < 50) begin
			it.kind = KIND_START;
		end else if (r < 88) begin
			it.kind = KIND_POLL;
		end else if (r < 92) begin
			it.kind = KIND_CLEAR;
		end else if (r < 96) begin
			// noise: full-range fields
			it.kind = ($urandom_range(0, 1) == 0) ? KIND_START : KIND_POLL;
			it.now = $urandom;
			it.start_delay = $urandom;
			it.period = $urandom;
		end else begin
			it.kind = kind_t'(2'd3);
		end
		send(it);
	endtask

	initial begin
		int cnt;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		idle_cycles = 0;
		gaps_on = 1'b0;
		t_now = 32'd1000;
		repeat (2) @(posedge clk);
		arst_n <= 1'b0;
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: empty poll, extremes, fill to full, reject, wrap, unknown kind
		send_item(KIND_POLL, 32'd0, 8'd0, 32'd0, 32'd0, 1'b0);
		send_item(KIND_START, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_item(KIND_START, 32'd5, 8'h00, 32'd0, 32'd0, 1'b0);
		send_item(KIND_START, 32'd5, 8'hAA, 32'd0, 32'd0, 1'b0);
		send_item(KIND_POLL, 32'd3, 8'd0, 32'd0, 32'd0, 1'b0);
		send_item(KIND_POLL, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_item(kind_t'(2'd3), 32'd1, 8'd1, 32'd1, 32'd1, 1'b1);
		send_item(KIND_CLEAR, 32'd0, 8'd0, 32'd0, 32'd0, 1'b0);
		for (int i = 0; i < NT + 1; i++)
			send_item(KIND_START, 32'd10, 8'(i), 32'(i % 3), 32'd2, 1'(i & 1));
		// a poll far ahead fires every timer; repeating ones go back in behind the rest and the next poll finds none due
		send_item(KIND_POLL, 32'hFFFF_FFF0, 8'd0, 32'd0, 32'd0, 1'b0);
		send_item(KIND_POLL, 32'd100, 8'd0, 32'd0, 32'd0, 1'b0);
		send_item(KIND_CLEAR, 32'd0, 8'd0, 32'd0, 32'd0, 1'b0);

		// random part, gaps on and off in stretches
		cnt = 0;
		while (cnt < 192) begin
			if (cnt % 40 == 0)
				gaps_on = (cnt % 80 == 0);
			random_item();
			cnt++;
		end
		in_valid <= 1'b0;
		while (sb.pending.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
